FILE: rtl/core/hdlc_pkg.sv
// hdlc_pkg: shared types, codes, constants and the crc-16/ppp byte update
// for the hdlc deframer with fcs check
// no dependencies
package hdlc_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 2048;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_GOOD = 16'hF0B8;

  localparam int KIND_W = 2;
  localparam int LEN_W  = 11;

  localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FRAME_END = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROP      = 2'd2;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic       is_flag;
    logic [7:0] value;
  } tok_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/hdlc_rx_if.sv
// hdlc_rx_if: valid/ready channel carrying one raw line byte per transfer
// no dependencies
interface hdlc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/core/hdlc_res_if.sv
// hdlc_res_if: valid/ready channel carrying one deframer result per transfer
// depends on hdlc_pkg
interface hdlc_res_if;
  import hdlc_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [7:0]        data;
  logic              fcs_ok;
  logic [LEN_W-1:0]  payload_length;

  modport source (output valid, output kind, output data, output fcs_ok,
                  output payload_length, input ready);
  modport sink (input valid, input kind, input data, input fcs_ok,
                input payload_length, output ready);
endinterface

FILE: rtl/core/hdlc_front.sv
// hdlc_front: accepts raw bytes, removes escapes and classifies each byte
// as flag or data token; depends on hdlc_pkg and hdlc_rx_if
module hdlc_front (
  input  logic           clk,
  input  logic           rst,
  hdlc_rx_if.sink        rx,
  output logic           tok_valid,
  output hdlc_pkg::tok_t tok,
  input  logic           tok_ready
);
  import hdlc_pkg::*;

  logic escape;
  logic escape_next;
  logic take;

  assign rx.ready = tok_ready;
  assign take     = rx.valid && rx.ready;

  always_comb begin
    escape_next   = escape;
    tok_valid     = 1'b0;
    tok.is_flag   = 1'b0;
    tok.value     = rx.rx_byte;
    if (rx.rx_byte == FLAG_BYTE) begin
      tok_valid   = rx.valid;
      tok.is_flag = 1'b1;
      escape_next = 1'b0;
    end else if (escape) begin
      tok_valid   = rx.valid;
      tok.value   = rx.rx_byte ^ ESC_XOR;
      escape_next = 1'b0;
    end else if (rx.rx_byte == ESC_BYTE) begin
      escape_next = 1'b1;
    end else begin
      tok_valid   = rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape <= 1'b0;
    end else if (take) begin
      escape <= escape_next;
    end
  end

endmodule

FILE: rtl/core/hdlc_queue.sv
// hdlc_queue: short token queue between the front and back parts
// depends on hdlc_pkg
module hdlc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hdlc_pkg::tok_t push_tok,
  output logic           not_full,
  input  logic           pop,
  output hdlc_pkg::tok_t pop_tok,
  output logic           not_empty
);
  import hdlc_pkg::*;

  tok_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign not_full  = count != Q_CW'(Q_DEPTH);
  assign not_empty = count != '0;
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_tok   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/hdlc_back.sv
// hdlc_back: frame state, running crc, two-byte holding delay and the
// registered result stage; depends on hdlc_pkg and hdlc_res_if
module hdlc_back #(
  parameter int MAX_FRAME_BYTES = hdlc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           tok_valid,
  input  hdlc_pkg::tok_t tok,
  output logic           tok_ready,
  hdlc_res_if.source     result
);
  import hdlc_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  logic             framed;
  logic [CNT_W-1:0] count;
  logic [15:0]      crc;
  logic [7:0]       held0;
  logic [7:0]       held1;
  logic             take;

  logic             emit;
  logic [KIND_W-1:0] kind_next;
  logic [7:0]       data_next;
  logic             ok_next;
  logic [CNT_W-1:0] len_full;
  logic [LEN_W-1:0] len_next;
  logic             at_max;
  logic             two_plus;

  assign tok_ready = !result.valid || result.ready;
  assign take      = tok_valid && tok_ready;
  assign at_max    = count == CNT_W'(MAX_FRAME_BYTES);
  assign two_plus  = count >= CNT_W'(2);
  assign len_full  = count - CNT_W'(2);

  always_comb begin
    emit      = 1'b0;
    kind_next = KIND_PAYLOAD;
    data_next = 8'h00;
    ok_next   = 1'b0;
    len_next  = '0;
    if (tok.is_flag) begin
      if (framed && two_plus) begin
        emit      = 1'b1;
        kind_next = KIND_FRAME_END;
        ok_next   = crc == CRC_GOOD;
        len_next  = LEN_W'(len_full);
      end
    end else if (framed) begin
      if (at_max) begin
        emit      = 1'b1;
        kind_next = KIND_DROP;
      end else if (two_plus) begin
        emit      = 1'b1;
        data_next = held0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      framed <= 1'b0;
      count  <= '0;
      crc    <= CRC_INIT;
    end else if (take) begin
      if (tok.is_flag) begin
        framed <= 1'b1;
        count  <= '0;
        crc    <= CRC_INIT;
      end else if (framed) begin
        if (at_max) begin
          framed <= 1'b0;
          count  <= '0;
        end else begin
          count <= count + 1'b1;
          crc   <= crc_byte(crc, tok.value);
        end
      end
    end
  end

  // holding delay, payload only
  always_ff @(posedge clk) begin
    if (take && !tok.is_flag && framed && !at_max) begin
      if (count == '0) begin
        held0 <= tok.value;
      end else if (count == CNT_W'(1)) begin
        held1 <= tok.value;
      end else begin
        held0 <= held1;
        held1 <= tok.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= emit;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      result.kind           <= kind_next;
      result.data           <= data_next;
      result.fcs_ok         <= ok_next;
      result.payload_length <= len_next;
    end
  end

endmodule

FILE: rtl/core/hdlc_deframer_fcs_check.sv
// hdlc_deframer_fcs_check: top level of the hdlc/ppp deframer with crc-16 fcs check
// depends on hdlc_pkg, hdlc_rx_if, hdlc_res_if, hdlc_front, hdlc_queue, hdlc_back
//
//   channel  role    payload
//   rx       sink    rx_byte[7:0]
//   result   source  kind[1:0], data[7:0], fcs_ok, payload_length[10:0]
//
// one byte per cycle sustained while result.ready stays high; a byte's token goes
// from the front into the two-entry queue, then the back stage registers its result
// the crc update of a whole byte is one combinational step in the back stage
// synchronous reset clears escape, queue pointers, frame state, crc and result valid
// a stalled result holds the back stage; rx stays open until the queue is full
module hdlc_deframer_fcs_check #(
  parameter int MAX_FRAME_BYTES = hdlc_pkg::MAX_FRAME_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  hdlc_rx_if.sink    rx,
  hdlc_res_if.source result
);
  import hdlc_pkg::*;

  logic q_push;
  tok_t q_in;
  logic q_not_full;
  logic q_pop;
  tok_t q_out;
  logic q_not_empty;

  hdlc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .tok_valid (q_push),
    .tok       (q_in),
    .tok_ready (q_not_full)
  );

  hdlc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_tok  (q_in),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .pop_tok   (q_out),
    .not_empty (q_not_empty)
  );

  hdlc_back #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_not_empty),
    .tok       (q_out),
    .tok_ready (q_pop),
    .result    (result)
  );

  // a full queue must close the input side
  a_full_blocks_rx: assert property (@(posedge clk) disable iff (rst)
    !q_not_full |-> !rx.ready)
    else $error("rx open while queue full");

  // a token pushed into an empty queue is visible to the back stage next cycle
  a_push_reaches_back: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_not_full && !q_not_empty) |=> q_not_empty)
    else $error("pushed token lost");

  // fields not used by a result kind read as zero
  a_unused_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind != KIND_PAYLOAD) |-> result.data == 8'h00)
    else $error("data nonzero on non-payload result");

  a_drop_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind == KIND_DROP) |->
      (!result.fcs_ok && result.payload_length == '0))
    else $error("drop result carries check fields");

endmodule
